// ===== rtl/core/fba_pkg.sv =====
`timescale 1ns / 1ps

package fba_pkg;

    // Bitmap geometry
    localparam int BITMAP_WORDS = 1024;
    localparam int WORD_BITS    = 32;
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    // Frontier index must also hold BITMAP_WORDS itself (bitmap exhausted)
    localparam int HINT_W       = $clog2(BITMAP_WORDS + 1);
    localparam int FRAME_NUM_W  = HINT_W + BIT_IDX_W;

    // Field widths
    localparam int CFG_W        = 11;
    localparam int FRAME_W      = 15;
    localparam int STATUS_W     = 2;
    localparam int LIM_W        = (CFG_W > HINT_W) ? CFG_W : HINT_W;

    localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};
    localparam logic [CFG_W-1:0]     WORDS_RESET = CFG_W'(1024);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd2;

    // Sequencer to frontier: mark one bit of the frontier word as used
    typedef struct packed {
        logic                 set;
        logic [BIT_IDX_W-1:0] bit_idx;
    } t_mark_cmd;

    // Frontier view: every word below hint is full, every word above is empty
    typedef struct packed {
        logic [HINT_W-1:0]    hint;
        logic [WORD_BITS-1:0] cur_word;
    } t_frontier;

endpackage

// ===== rtl/core/fba_bit_scan.sv =====
`timescale 1ns / 1ps

// Shift-and-test unit: walks a word one bit per cycle looking for a zero.
module fba_bit_scan import fba_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [WORD_BITS-1:0] i_word,
    output logic                 o_hit,
    output logic [BIT_IDX_W-1:0] o_index
);

    logic [WORD_BITS-1:0] r_shift;
    logic [WORD_BITS-1:0] n_shift;
    logic [BIT_IDX_W-1:0] r_idx;
    logic [BIT_IDX_W-1:0] n_idx;

    assign o_hit   = ~r_shift[0];
    assign o_index = r_idx;

    always_comb begin
        n_shift = r_shift;
        n_idx   = r_idx;
        if (i_load) begin
            n_shift = i_word;
            n_idx   = '0;
        end else if (!o_hit) begin
            // fill with ones so nothing past the top reads as free
            n_shift = {1'b1, r_shift[WORD_BITS-1:1]};
            n_idx   = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= FULL_WORD;
            r_idx   <= '0;
        end else begin
            r_shift <= n_shift;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== rtl/core/fba_frontier.sv =====
`timescale 1ns / 1ps

// Allocation frontier. Frames are only ever set, in first-fit order, so the
// bitmap is words [0, hint) full, word hint partly used, the rest clear.
module fba_frontier import fba_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mark_cmd i_mark,
    output t_frontier o_front
);

    logic [HINT_W-1:0]    r_hint;
    logic [HINT_W-1:0]    n_hint;
    logic [WORD_BITS-1:0] r_cur_word;
    logic [WORD_BITS-1:0] n_cur_word;
    logic [WORD_BITS-1:0] w_marked;

    assign w_marked = r_cur_word | (WORD_BITS'(1) << i_mark.bit_idx);

    always_comb begin
        n_hint     = r_hint;
        n_cur_word = r_cur_word;
        if (i_mark.set) begin
            if (w_marked == FULL_WORD) begin
                // advance to the next word, which has never been touched
                n_hint     = r_hint + 1'b1;
                n_cur_word = '0;
            end else begin
                n_cur_word = w_marked;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint     <= '0;
            r_cur_word <= '0;
        end else begin
            r_hint     <= n_hint;
            r_cur_word <= n_cur_word;
        end
    end

    assign o_front.hint     = r_hint;
    assign o_front.cur_word = r_cur_word;

endmodule

// ===== rtl/core/frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps

// Already-mapped and no-free-frame results strobe in the cycle after start is taken.
// Allocation strobes once the shift-and-test unit, testing one bit per cycle,
// reaches the lowest clear bit (position 0..31) of the frontier word. busy stays
// high until the strobe, so no request is taken during a scan; requests that need
// no allocation can be taken one per cycle. The receiver cannot stall.
// Reset (sync, active low): every frame free, words_in_use = 1024, no sweep.
module frame_bitmap_allocator import fba_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  logic [FRAME_W-1:0]  i_existing_frame,
    input  logic                i_kernel_page,
    input  logic                i_read_only,
    // configuration
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    // result side
    output logic                o_result_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_present,
    output logic                o_writable,
    output logic                o_user,
    output logic [FRAME_W-1:0]  o_frame
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    // configuration register
    logic [CFG_W-1:0] r_words_in_use;

    // flags of the transaction in flight
    logic r_kernel;
    logic r_ronly;

    // result register
    logic                r_res_valid;
    logic                n_res_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                r_present;
    logic                n_present;
    logic                r_writable;
    logic                n_writable;
    logic                r_user;
    logic                n_user;
    logic [FRAME_W-1:0]  r_frame;
    logic [FRAME_W-1:0]  n_frame;

    logic                   w_accept;
    logic                   w_scan_load;
    logic                   w_scan_hit;
    logic [BIT_IDX_W-1:0]   w_scan_idx;
    logic [LIM_W-1:0]       w_limit;
    logic                   w_has_free;
    logic [FRAME_NUM_W-1:0] w_frame_num;
    t_mark_cmd              w_mark;
    t_frontier              w_front;

    assign w_accept = start && !busy;
    assign busy     = (r_state == S_SCAN);

    // Saturate the scan length to the bitmap size; words below the frontier
    // are full, so a free frame exists only while the frontier is in range.
    assign w_limit    = (LIM_W'(r_words_in_use) > LIM_W'(BITMAP_WORDS)) ?
                        LIM_W'(BITMAP_WORDS) : LIM_W'(r_words_in_use);
    assign w_has_free = LIM_W'(w_front.hint) < w_limit;

    assign w_frame_num = {w_front.hint, w_scan_idx};

    assign w_scan_load    = w_accept && (i_existing_frame == '0) && w_has_free;
    assign w_mark.set     = (r_state == S_SCAN) && w_scan_hit;
    assign w_mark.bit_idx = w_scan_idx;

    fba_bit_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_scan_load),
        .i_word  (w_front.cur_word),
        .o_hit   (w_scan_hit),
        .o_index (w_scan_idx)
    );

    fba_frontier u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mark  (w_mark),
        .o_front (w_front)
    );

    // Sequencer: answer mapped / no-free at once, otherwise scan the
    // frontier word and claim its lowest clear bit.
    always_comb begin
        n_state     = r_state;
        n_res_valid = 1'b0;
        n_status    = r_status;
        n_present   = r_present;
        n_writable  = r_writable;
        n_user      = r_user;
        n_frame     = r_frame;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_existing_frame != '0) begin
                        // leave the entry as is, echo its frame
                        n_res_valid = 1'b1;
                        n_status    = ST_MAPPED;
                        n_present   = 1'b0;
                        n_writable  = 1'b0;
                        n_user      = 1'b0;
                        n_frame     = i_existing_frame;
                    end else if (!w_has_free) begin
                        n_res_valid = 1'b1;
                        n_status    = ST_NOFREE;
                        n_present   = 1'b0;
                        n_writable  = 1'b0;
                        n_user      = 1'b0;
                        n_frame     = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_hit) begin
                    n_res_valid = 1'b1;
                    n_status    = ST_ALLOC;
                    n_present   = 1'b1;
                    n_writable  = ~r_ronly;
                    n_user      = ~r_kernel;
                    n_frame     = FRAME_W'(w_frame_num);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_res_valid    <= 1'b0;
            r_words_in_use <= WORDS_RESET;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_words_in_use <= i_cfg_wdata;
            end
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_present  <= n_present;
        r_writable <= n_writable;
        r_user     <= n_user;
        r_frame    <= n_frame;
        if (w_accept) begin
            r_kernel <= i_kernel_page;
            r_ronly  <= i_read_only;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;
    assign o_present      = r_present;
    assign o_writable     = r_writable;
    assign o_user         = r_user;
    assign o_frame        = r_frame;

    // Every accepted transaction either scans or answers on the next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (busy || o_result_valid))
        else $error("accepted transaction neither scanning nor answered");

    // The frontier word is never full, so the scan cannot run past the top bit.
    a_scan_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (w_scan_hit || (w_scan_idx != {BIT_IDX_W{1'b1}})))
        else $error("bit scan ran past the frontier word");

    // The frontier holds while a scan is still searching.
    a_front_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_scan_hit) |=> $stable(w_front.hint)
        && $stable(w_front.cur_word))
        else $error("frontier moved during a scan");

    // An allocation result always carries the present bit.
    a_alloc_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_ALLOC) |-> o_present)
        else $error("allocated entry without present bit");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and checking for the frame bitmap allocator.
// Requests go in through the start/busy handshake. A local copy of the bitmap and
// of the scan length predicts each result at the moment the request is taken. A
// checker pops the oldest prediction on every result strobe and compares it field
// by field.
module testbench;
    import fba_pkg::*;

    // Expected contents of one result strobe
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                present;
        logic                writable;
        logic                user;
        logic [FRAME_W-1:0]  frame;
    } t_alloc_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FRAME_W-1:0]  i_existing_frame = '0;
    logic                i_kernel_page = 1'b0;
    logic                i_read_only = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;
    logic                o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_present;
    logic                o_writable;
    logic                o_user;
    logic [FRAME_W-1:0]  o_frame;

    // Shadow of the allocator: one bit per frame, plus the scan length register
    logic [WORD_BITS-1:0] used_map [BITMAP_WORDS];
    logic [CFG_W-1:0]     scan_words = WORDS_RESET;

    t_alloc_result pending_results [$];
    int            fail_count = 0;
    int            requests_sent = 0;
    int            burst_left = 0;

    frame_bitmap_allocator i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_existing_frame (i_existing_frame),
        .i_kernel_page    (i_kernel_page),
        .i_read_only      (i_read_only),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_present        (o_present),
        .o_writable       (o_writable),
        .o_user           (o_user),
        .o_frame          (o_frame)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // First-fit claim against the shadow bitmap. A mapped entry passes through
    // untouched; otherwise take the lowest clear bit within the scanned words,
    // with the scan length capped at the size of the store.
    function automatic t_alloc_result claim_frame(input logic [FRAME_W-1:0] existing,
                                                  input logic kernel, input logic ro);
        t_alloc_result r;
        int            limit;
        int            frame_no;
        bit            found;
        r.status   = ST_MAPPED;
        r.present  = 1'b0;
        r.writable = 1'b0;
        r.user     = 1'b0;
        r.frame    = existing;
        if (existing != '0) return r;
        limit    = (int'(scan_words) > BITMAP_WORDS) ? BITMAP_WORDS : int'(scan_words);
        found    = 1'b0;
        frame_no = 0;
        for (int w = 0; w < limit && !found; w++) begin
            if (used_map[w] != FULL_WORD) begin
                for (int b = 0; b < WORD_BITS && !found; b++) begin
                    if (!used_map[w][b]) begin
                        found    = 1'b1;
                        frame_no = w * WORD_BITS + b;
                    end
                end
            end
        end
        if (!found) begin
            r.status = ST_NOFREE;
            r.frame  = '0;
            return r;
        end
        used_map[frame_no / WORD_BITS][frame_no % WORD_BITS] = 1'b1;
        r.status   = ST_ALLOC;
        r.present  = 1'b1;
        r.writable = ~ro;
        r.user     = ~kernel;
        r.frame    = FRAME_W'(frame_no);
        return r;
    endfunction

    // Send one request. Traffic comes in bursts: when a burst runs out, drop start
    // for a random gap and pick the next burst length. start stays high between
    // back-to-back requests, so only the payload changes at that falling edge.
    task automatic send_request(input logic [FRAME_W-1:0] existing,
                                input logic kernel, input logic ro);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6, 0);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
            burst_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(12, 1);
        end
        burst_left--;
        @(negedge i_clk);
        start            <= 1'b1;
        i_existing_frame <= existing;
        i_kernel_page    <= kernel;
        i_read_only      <= ro;
        // Hold the request until an edge sees busy low
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending_results.push_back(claim_frame(existing, kernel, ro));
        requests_sent++;
    endtask

    // Drop start and let every outstanding transaction come back, then idle with start
    // low. A missing result is reported once and the queue is flushed.
    task automatic wait_idle();
        int waited;
        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 500) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            report_mismatch("results still pending", 0, pending_results.size());
            pending_results.delete();
        end
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic set_scan_words(input logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        scan_words = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result checker: every strobe must match the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_alloc_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, status", int'(o_status), -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_present !== want.present)
                    report_mismatch("present", int'(o_present), int'(want.present));
                if (o_writable !== want.writable)
                    report_mismatch("writable", int'(o_writable), int'(want.writable));
                if (o_user !== want.user)
                    report_mismatch("user", int'(o_user), int'(want.user));
                if (o_frame !== want.frame)
                    report_mismatch("frame", int'(o_frame), int'(want.frame));
            end
        end
    end

    // Fresh bitmap at full scan length: one allocation per flag combination,
    // starting from frame zero, which is an ordinary frame.
    task automatic test_entry_flags();
        for (int f = 0; f < 4; f++)
            send_request('0, f[0], f[1]);
    endtask

    // Mapped entries echo the frame and ignore the flags; walk the frame field
    // through its extremes and alternating patterns.
    task automatic test_already_mapped();
        send_request(15'h7FFF, 1'b1, 1'b1);
        send_request(15'h0001, 1'b0, 1'b0);
        send_request(15'h5555, 1'b1, 1'b0);
        send_request(15'h2AAA, 1'b0, 1'b1);
        send_request(15'h4000, 1'b1, 1'b1);
    endtask

    // A scan length of zero covers no word: every unmapped request finds nothing
    task automatic test_empty_scan();
        set_scan_words('0);
        send_request('0, 1'b0, 1'b0);
        send_request('0, 1'b1, 1'b1);
        send_request(15'h0003, 1'b0, 1'b0);
    endtask

    // Register at its top value: scan length saturates at the store size; then one word
    task automatic test_scan_saturation();
        set_scan_words({CFG_W{1'b1}});
        send_request('0, 1'b0, 1'b1);
        send_request('0, 1'b1, 1'b0);
        send_request('0, 1'b0, 1'b0);
        set_scan_words(CFG_W'(1));
        send_request('0, 1'b1, 1'b1);
    endtask

    // Random phases. Most phases set the scan length right at the frontier of the
    // filled words, so words fill up and then run dry; the rest use the extremes
    // or a random length. Three in four requests are unmapped.
    task automatic test_random_traffic(input int item_count);
        int first_open;
        int pick;
        int phase_len;
        int target;
        logic [CFG_W-1:0] next_words;
        target = requests_sent + item_count;
        while (requests_sent < target) begin
            first_open = 0;
            while (first_open < BITMAP_WORDS && used_map[first_open] == FULL_WORD)
                first_open++;
            pick = $urandom_range(9, 0);
            case (pick)
                0: next_words = '0;
                1: next_words = {CFG_W{1'b1}};
                2: next_words = CFG_W'(BITMAP_WORDS);
                3: next_words = CFG_W'($urandom_range(2046, 1));
                default: begin
                    next_words = CFG_W'(first_open + $urandom_range(1, 0));
                end
            endcase
            set_scan_words(next_words);
            phase_len = $urandom_range(50, 15);
            for (int n = 0; n < phase_len && requests_sent < target; n++) begin
                if ($urandom_range(3, 0) != 0)
                    send_request('0, 1'($urandom), 1'($urandom));
                else
                    send_request(FRAME_W'($urandom_range(32767, 1)),
                                 1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        for (int w = 0; w < BITMAP_WORDS; w++)
            used_map[w] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_entry_flags();
        test_already_mapped();
        test_empty_scan();
        test_scan_saturation();
        test_random_traffic(750);

        // Drain, then allow the longest allocation latency to pass
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
